// ----- src/nqcc_pkg.sv -----
// Package for the N-queens completion counter: shared constants, payload
// structs and the lane and search control structs.
// No dependencies; every other file in src uses it.
package nqcc_pkg;

  localparam int MaxBoard  = 12;
  localparam int RowIdxW   = $clog2(MaxBoard);        // 0-based row or column
  localparam int RowNumW   = $clog2(MaxBoard + 1);    // 1-based row, 0 = none
  localparam int DiagCnt   = 2 * MaxBoard - 1;
  localparam int DiagIdxW  = $clog2(DiagCnt);
  localparam int TallyW    = 14;
  localparam int SizeW     = 4;

  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  // Configuration port.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgAddrW-1:0] RegBoardSize   = CfgAddrW'(0);
  localparam logic [SizeW-1:0]    BoardSizeReset = SizeW'(8);

  typedef struct packed {
    logic [MaxBoard-1:0] row_cells;
    logic                last_row;
  } in_item_t;

  typedef struct packed {
    logic [TallyW-1:0] solution_count;
    logic              given_conflict;
  } out_item_t;

  // What one column lane reports about its given queen.
  typedef struct packed {
    logic                has;
    logic [RowIdxW-1:0]  row;
    logic [DiagIdxW-1:0] d1;
    logic [DiagIdxW-1:0] d2;
    logic                dup;
  } lane_out_t;

  // Occupancy of the given queens, handed to the search engine at start.
  typedef struct packed {
    logic [MaxBoard-1:0] rows;
    logic [DiagCnt-1:0]  d1;
    logic [DiagCnt-1:0]  d2;
    logic [MaxBoard-1:0] given_cols;
  } srch_init_t;

endpackage

// ----- src/nqcc_col_lane.sv -----
// One column lane: holds the row of the given queen in its column, loads it
// from incoming rows and reports its row and diagonals for the current size.
// Depends on nqcc_pkg.
module nqcc_col_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [nqcc_pkg::RowIdxW-1:0] col_idx,
  input  logic [nqcc_pkg::SizeW-1:0]   n,
  input  logic                         load,
  input  logic                         row_bit,
  input  logic [nqcc_pkg::RowNumW-1:0] load_row,
  input  logic                         clear,
  output nqcc_pkg::lane_out_t          lane_out
);

  logic [nqcc_pkg::RowNumW-1:0] given_r;
  logic                         col_on;
  logic                         hit;

  assign col_on = (nqcc_pkg::SizeW'(col_idx) < n);
  assign hit    = load && row_bit && col_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      given_r <= '0;
    end else if (clear) begin
      given_r <= '0;
    end else if (hit && (given_r == '0)) begin
      given_r <= load_row;
    end
  end

  always_comb begin
    lane_out.has = col_on && (given_r != '0) && (nqcc_pkg::SizeW'(given_r) <= n);
    lane_out.row = nqcc_pkg::RowIdxW'(given_r - nqcc_pkg::RowNumW'(1));
    lane_out.d1  = nqcc_pkg::DiagIdxW'(col_idx) + nqcc_pkg::DiagIdxW'(nqcc_pkg::MaxBoard - 1)
                   - nqcc_pkg::DiagIdxW'(lane_out.row);
    lane_out.d2  = nqcc_pkg::DiagIdxW'(col_idx) + nqcc_pkg::DiagIdxW'(lane_out.row);
    lane_out.dup = hit && (given_r != '0);
  end

endmodule

// ----- src/nqcc_search.sv -----
// Backtracking search engine: walks the columns one step per cycle, tests
// all rows of a column in parallel and counts complete placements.
// Depends on nqcc_pkg.
module nqcc_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  nqcc_pkg::srch_init_t        init,
  input  logic [nqcc_pkg::SizeW-1:0]  n,
  output logic                        done,
  output logic [nqcc_pkg::TallyW-1:0] tally
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ENTER = 2'd1;
  localparam logic [1:0] S_TRY   = 2'd2;
  localparam logic [1:0] S_BACK  = 2'd3;

  localparam int ColW = nqcc_pkg::RowNumW;

  logic [1:0]                         state_r;
  logic [ColW-1:0]                    col_r;
  logic [nqcc_pkg::MaxBoard-1:0]      rows_r;
  logic [nqcc_pkg::DiagCnt-1:0]       d1_r;
  logic [nqcc_pkg::DiagCnt-1:0]       d2_r;
  logic [nqcc_pkg::MaxBoard-1:0]      given_cols_r;
  logic [nqcc_pkg::MaxBoard-1:0]      avail_r  [nqcc_pkg::MaxBoard];
  logic [nqcc_pkg::RowIdxW-1:0]       chosen_r [nqcc_pkg::MaxBoard];
  logic [nqcc_pkg::TallyW-1:0]        tally_r;
  logic                               done_r;

  logic [nqcc_pkg::RowIdxW-1:0]       cidx;
  logic [nqcc_pkg::RowIdxW-1:0]       bidx;
  logic [nqcc_pkg::MaxBoard-1:0]      free_rows;
  logic [nqcc_pkg::MaxBoard-1:0]      cur_avail;
  logic                               pick_any;
  logic [nqcc_pkg::RowIdxW-1:0]       pick_idx;
  logic [nqcc_pkg::DiagIdxW-1:0]      pd1;
  logic [nqcc_pkg::DiagIdxW-1:0]      pd2;
  logic [nqcc_pkg::RowIdxW-1:0]       back_row;
  logic [nqcc_pkg::DiagIdxW-1:0]      bd1;
  logic [nqcc_pkg::DiagIdxW-1:0]      bd2;

  assign cidx = (col_r < ColW'(nqcc_pkg::MaxBoard)) ? col_r[nqcc_pkg::RowIdxW-1:0] : '0;
  assign bidx = (col_r != '0) ? nqcc_pkg::RowIdxW'(col_r - ColW'(1)) : '0;

  // One lane per row: a row is free when neither it nor its two diagonals
  // through the current column are taken.
  always_comb begin
    for (int r = 0; r < nqcc_pkg::MaxBoard; r++) begin
      free_rows[r] = (nqcc_pkg::SizeW'(r) < n) && !rows_r[r]
        && !d1_r[nqcc_pkg::DiagIdxW'(cidx) + nqcc_pkg::DiagIdxW'(nqcc_pkg::MaxBoard - 1)
                 - nqcc_pkg::DiagIdxW'(r)]
        && !d2_r[nqcc_pkg::DiagIdxW'(cidx) + nqcc_pkg::DiagIdxW'(r)];
    end
  end

  // Lowest remaining candidate row of the current column.
  always_comb begin
    cur_avail = avail_r[cidx];
    pick_any  = 1'b0;
    pick_idx  = '0;
    for (int r = nqcc_pkg::MaxBoard - 1; r >= 0; r--) begin
      if (cur_avail[r]) begin
        pick_any = 1'b1;
        pick_idx = nqcc_pkg::RowIdxW'(r);
      end
    end
  end

  assign pd1 = nqcc_pkg::DiagIdxW'(cidx) + nqcc_pkg::DiagIdxW'(nqcc_pkg::MaxBoard - 1)
               - nqcc_pkg::DiagIdxW'(pick_idx);
  assign pd2 = nqcc_pkg::DiagIdxW'(cidx) + nqcc_pkg::DiagIdxW'(pick_idx);

  assign back_row = chosen_r[bidx];
  assign bd1 = nqcc_pkg::DiagIdxW'(bidx) + nqcc_pkg::DiagIdxW'(nqcc_pkg::MaxBoard - 1)
               - nqcc_pkg::DiagIdxW'(back_row);
  assign bd2 = nqcc_pkg::DiagIdxW'(bidx) + nqcc_pkg::DiagIdxW'(back_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      tally_r <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            rows_r       <= init.rows;
            d1_r         <= init.d1;
            d2_r         <= init.d2;
            given_cols_r <= init.given_cols;
            col_r        <= '0;
            tally_r      <= '0;
            state_r      <= S_ENTER;
          end
        end
        S_ENTER: begin
          if (nqcc_pkg::SizeW'(col_r) == n) begin
            if (tally_r != nqcc_pkg::TallyMax) begin
              tally_r <= tally_r + nqcc_pkg::TallyW'(1);
            end
            state_r <= S_BACK;
          end else if (given_cols_r[cidx]) begin
            col_r <= col_r + ColW'(1);
          end else begin
            avail_r[cidx] <= free_rows;
            state_r       <= S_TRY;
          end
        end
        S_TRY: begin
          if (pick_any) begin
            rows_r[pick_idx]        <= 1'b1;
            d1_r[pd1]               <= 1'b1;
            d2_r[pd2]               <= 1'b1;
            chosen_r[cidx]          <= pick_idx;
            avail_r[cidx][pick_idx] <= 1'b0;
            col_r                   <= col_r + ColW'(1);
            state_r                 <= S_ENTER;
          end else begin
            state_r <= S_BACK;
          end
        end
        S_BACK: begin
          if (col_r == '0) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            col_r <= col_r - ColW'(1);
            // Given columns are stepped over; a searched column releases its
            // queen and resumes with its next candidate.
            if (!given_cols_r[bidx]) begin
              rows_r[back_row] <= 1'b0;
              d1_r[bd1]        <= 1'b0;
              d2_r[bd2]        <= 1'b0;
              state_r          <= S_TRY;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign tally = tally_r;

endmodule

// ----- src/n_queens_completion_counter_top.sv -----
// N-queens completion counter, top level: rows are accepted back to back while
// loading. After the final row the given queens are checked in ST_PREP; a conflict
// is reported at once with given_conflict set, else the backtracking search runs
// its walk of enter, try and back steps. The search result is captured in an
// output register when the search reports done.
// Reset (synchronous, active low) sets board_size to 8 and clears the board.
// Depends on nqcc_pkg, nqcc_col_lane and nqcc_search.
module n_queens_completion_counter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nqcc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nqcc_pkg::out_item_t             out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [nqcc_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [nqcc_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [nqcc_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                            cfg_pready
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;

  logic [1:0]                         state_r;
  logic [nqcc_pkg::SizeW-1:0]         board_size_r;
  logic [nqcc_pkg::RowNumW-1:0]       rows_loaded_r;
  logic                               conflict_seen_r;
  logic                               out_valid_r;
  nqcc_pkg::out_item_t                out_data_r;

  logic [nqcc_pkg::SizeW-1:0]         n;
  logic                               in_xfer;
  logic                               load_en;
  logic                               lane_clear;
  nqcc_pkg::lane_out_t                lanes [nqcc_pkg::MaxBoard];
  logic [nqcc_pkg::MaxBoard-1:0]      dup_vec;
  logic                               attack;
  logic                               conflict_any;
  nqcc_pkg::srch_init_t               init;
  logic                               srch_start;
  logic                               srch_done;
  logic [nqcc_pkg::TallyW-1:0]        srch_tally;

  always_comb begin
    if (board_size_r == '0) begin
      n = nqcc_pkg::SizeW'(1);
    end else if (board_size_r > nqcc_pkg::SizeW'(nqcc_pkg::MaxBoard)) begin
      n = nqcc_pkg::SizeW'(nqcc_pkg::MaxBoard);
    end else begin
      n = board_size_r;
    end
  end

  // A final row waits while a result is still pending; other rows do not.
  assign in_ready   = (state_r == ST_LOAD) && (!in_data.last_row || !out_valid_r);
  assign in_xfer    = in_valid && in_ready;
  assign load_en    = in_xfer && (nqcc_pkg::SizeW'(rows_loaded_r) < n);
  assign lane_clear = (state_r == ST_PREP);

  for (genvar j = 0; j < nqcc_pkg::MaxBoard; j++) begin : g_lane
    nqcc_col_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .col_idx  (nqcc_pkg::RowIdxW'(j)),
      .n        (n),
      .load     (load_en),
      .row_bit  (in_data.row_cells[j]),
      .load_row (rows_loaded_r + nqcc_pkg::RowNumW'(1)),
      .clear    (lane_clear),
      .lane_out (lanes[j])
    );
  end

  // Merge the lanes: occupancy masks for the search and a pairwise check
  // of the given queens against each other.
  always_comb begin
    init   = '0;
    attack = 1'b0;
    for (int j = 0; j < nqcc_pkg::MaxBoard; j++) begin
      dup_vec[j]         = lanes[j].dup;
      init.given_cols[j] = lanes[j].has;
      if (lanes[j].has) begin
        init.rows[lanes[j].row] = 1'b1;
        init.d1[lanes[j].d1]    = 1'b1;
        init.d2[lanes[j].d2]    = 1'b1;
      end
      for (int k = j + 1; k < nqcc_pkg::MaxBoard; k++) begin
        if (lanes[j].has && lanes[k].has &&
            ((lanes[j].row == lanes[k].row) || (lanes[j].d1 == lanes[k].d1) ||
             (lanes[j].d2 == lanes[k].d2))) begin
          attack = 1'b1;
        end
      end
    end
  end

  assign conflict_any = conflict_seen_r || attack;
  assign srch_start   = (state_r == ST_PREP) && !conflict_any;

  nqcc_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .init  (init),
    .n     (n),
    .done  (srch_done),
    .tally (srch_tally)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_LOAD;
      board_size_r    <= nqcc_pkg::BoardSizeReset;
      rows_loaded_r   <= '0;
      conflict_seen_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == nqcc_pkg::RegBoardSize)) begin
        board_size_r <= cfg_pwdata[nqcc_pkg::SizeW-1:0];
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_xfer) begin
            if (load_en) begin
              rows_loaded_r <= rows_loaded_r + nqcc_pkg::RowNumW'(1);
            end
            if (|dup_vec) begin
              conflict_seen_r <= 1'b1;
            end
            if (in_data.last_row) begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          rows_loaded_r   <= '0;
          conflict_seen_r <= 1'b0;
          if (conflict_any) begin
            out_valid_r                <= 1'b1;
            out_data_r.solution_count  <= '0;
            out_data_r.given_conflict  <= 1'b1;
            state_r                    <= ST_LOAD;
          end else begin
            state_r <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (srch_done) begin
            out_valid_r                <= 1'b1;
            out_data_r.solution_count  <= srch_tally;
            out_data_r.given_conflict  <= 1'b0;
            state_r                    <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_prdata = (cfg_paddr == nqcc_pkg::RegBoardSize) ?
                      nqcc_pkg::CfgDataW'(board_size_r) : '0;
  assign cfg_pready = 1'b1;

endmodule
